@@ hdl/hrd_pkg.sv @@
// Holiday rule resolver package: rule kind codes, calendar tables,
// constant-divisor helpers and the stage record type.
// No dependencies.
`timescale 1ns / 1ps
package hrd_pkg;

  localparam logic [2:0] FN_FIXED   = 3'd0;
  localparam logic [2:0] FN_EASTER  = 3'd1;
  localparam logic [2:0] FN_ADVENT  = 3'd2;
  localparam logic [2:0] FN_NTH     = 3'd3;
  localparam logic [2:0] FN_ONAFTER = 3'd4;

  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_DEC = 4'd12;

  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    unique case (m)
      4'd2:                      r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] dow_tab(input logic [3:0] m);
    logic [2:0] r;
    unique case (m)
      4'd1:    r = 3'd0;
      4'd2:    r = 3'd3;
      4'd3:    r = 3'd2;
      4'd4:    r = 3'd5;
      4'd5:    r = 3'd0;
      4'd6:    r = 3'd3;
      4'd7:    r = 3'd5;
      4'd8:    r = 3'd1;
      4'd9:    r = 3'd4;
      4'd10:   r = 3'd6;
      4'd11:   r = 3'd2;
      4'd12:   r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // x mod 7 by reciprocal multiply, exact for x below 13000
  function automatic logic [2:0] mod7(input logic [12:0] x);
    logic [26:0] p;
    logic [12:0] r;
    p = 27'(x) * 27'(14'd9363);
    r = x - 13'({2'b0, p[26:16]} * 13'd7);
    return r[2:0];
  endfunction

  typedef struct packed {
    logic              ok;
    logic [2:0]        func;
    logic [2:0]        wk;
    logic [3:0]        mon;
    logic signed [7:0] dv;
    logic [4:0]        a;
    logic [5:0]        b;
    logic [3:0]        d;
    logic [1:0]        e;
    logic [4:0]        i;
    logic [1:0]        k;
    logic [1:0]        f;
    logic              leap;
    logic [2:0]        yc0;
    logic [2:0]        yc1;
  } year_info_t;

endpackage

@@ hdl/hrd_year.sv @@
// Year decomposition stages: Easter terms, leap flag, weekday year codes.
// Depends on hrd_pkg.
`timescale 1ns / 1ps
module hrd_year import hrd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  logic [2:0]        func,
  input  logic [2:0]        weekday,
  input  logic [3:0]        month,
  input  logic signed [7:0] day_offset,
  input  logic [11:0]       rule_year,
  input  logic [11:0]       year,
  output logic              out_vld,
  output year_info_t        info
);

  logic        vld1;
  logic        ok1;
  logic [2:0]  func1, wk1;
  logic [3:0]  mon1;
  logic signed [7:0] dv1;
  logic [11:0] y1;
  logic [4:0]  a1;
  logic [5:0]  b1;
  logic [6:0]  c1;
  logic [6:0]  p01;

  logic        mok, ok_c;
  logic [23:0] q19p;
  logic [11:0] t19;
  logic [24:0] bp;
  logic [5:0]  b_c;
  logic [12:0] yy0_c;
  logic [25:0] p0p;

  always_comb begin
    mok = (month >= 4'd1) && (month <= 4'd12);
    unique case (func)
      FN_FIXED:   ok_c = mok && day_offset >= 8'sd1 && day_offset <= 8'sd31 &&
                         (rule_year == 12'd0 || rule_year == year);
      FN_EASTER,
      FN_ADVENT:  ok_c = (month == 4'd0);
      FN_NTH:     ok_c = mok && day_offset >= 8'sd1 && day_offset <= 8'sd5 &&
                         weekday <= 3'd6;
      FN_ONAFTER: ok_c = mok && day_offset >= 8'sd1 && day_offset <= 8'sd31 &&
                         weekday <= 3'd6;
      default:    ok_c = 1'b0;
    endcase
    q19p  = 24'(year) * 24'(12'd3450);
    t19   = 12'({4'b0, q19p[23:16]} * 12'd19);
    bp    = 25'(year) * 25'(13'd5243);
    b_c   = bp[24:19];
    yy0_c = 13'(year) + 13'd399;
    p0p   = 26'(yy0_c) * 26'(13'd5243);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    ok1   <= ok_c;
    func1 <= func;
    wk1   <= weekday;
    mon1  <= month;
    dv1   <= day_offset;
    y1    <= year;
    a1    <= 5'(year - t19);
    b1    <= b_c;
    c1    <= 7'(year - 12'({6'b0, b_c} * 12'd100));
    p01   <= p0p[25:19];
  end

  logic [12:0] yy0, yy1;
  logic [13:0] sum0, sum1;
  logic [5:0]  bs;
  logic [11:0] fp;
  year_info_t  info_next;

  always_comb begin
    yy0  = 13'(y1) + 13'd399;
    yy1  = 13'(y1) + 13'd400;
    sum1 = 14'(yy1) + 14'(yy1[12:2]) - 14'(b1) - 14'd4 + 14'(b1[5:2]) + 14'd1;
    sum0 = 14'(yy0) + 14'(yy0[12:2]) - 14'(p01) + 14'(p01[6:2]);
    bs   = b1 + 6'd8;
    fp   = 12'(bs) * 12'd41;
    info_next.ok   = ok1;
    info_next.func = func1;
    info_next.wk   = wk1;
    info_next.mon  = mon1;
    info_next.dv   = dv1;
    info_next.a    = a1;
    info_next.b    = b1;
    info_next.d    = b1[5:2];
    info_next.e    = b1[1:0];
    info_next.i    = c1[6:2];
    info_next.k    = c1[1:0];
    info_next.f    = fp[11:10];
    info_next.leap = (y1[1:0] == 2'd0 && c1 != 7'd0) ||
                     (c1 == 7'd0 && b1[1:0] == 2'd0);
    info_next.yc0  = mod7(sum0[12:0]);
    info_next.yc1  = mod7(sum1[12:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    info <= info_next;
  end

endmodule

@@ hdl/hrd_resolve.sv @@
// Rule resolution stages: weekday, Easter tail, per-kind day of year.
// Depends on hrd_pkg.
`timescale 1ns / 1ps
module hrd_resolve import hrd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  year_info_t        info,
  output logic              done,
  output logic              valid_res,
  output logic signed [9:0] day_index
);

  logic [2:0] vld;

  // stage 3
  logic [5:0]  gx;
  logic [10:0] gp;
  logic [4:0]  ml_c, dd_c;
  logic        spill;
  logic [3:0]  dm;
  logic [2:0]  yc;
  logic [8:0]  ydb_c;

  year_info_t  x3;
  logic [3:0]  g3;
  logic [4:0]  ml3, dd3;
  logic [3:0]  dcode3;
  logic [8:0]  ydb3;

  always_comb begin
    gx    = info.b - {4'b0, info.f} + 6'd1;
    gp    = 11'(gx) * 11'd43;
    ml_c  = month_len(info.mon, info.leap);
    spill = (info.dv[4:0] > ml_c);
    unique case (info.func)
      FN_ADVENT: begin
        dm   = MON_DEC;
        dd_c = 5'd24;
      end
      FN_NTH: begin
        dm   = info.mon;
        dd_c = 5'd1;
      end
      default: begin
        dm   = spill ? 4'(info.mon + 4'd1) : info.mon;
        dd_c = spill ? 5'(info.dv[4:0] - ml_c) : info.dv[4:0];
      end
    endcase
    yc    = (dm < 4'd3) ? info.yc0 : info.yc1;
    ydb_c = days_before(info.mon) + 9'(info.dv[4:0]) - 9'd1 +
            9'((info.mon > MON_FEB) && info.leap);
  end

  always_ff @(posedge clk) begin
    x3     <= info;
    g3     <= gp[10:7];
    ml3    <= ml_c;
    dd3    <= dd_c;
    dcode3 <= 4'(yc) + 4'(dow_tab(dm));
    ydb3   <= ydb_c;
  end

  // stage 4
  logic [9:0]  hx;
  logic [19:0] hp;
  year_info_t  x4;
  logic [4:0]  h4, ml4, dd4;
  logic [2:0]  dow4;
  logic [8:0]  ydb4;

  always_comb begin
    hx = 10'(10'(x3.a) * 10'd19) + 10'(x3.b) + 10'd15 - 10'(x3.d) - 10'(g3);
    hp = 20'(hx) * 20'd547;
  end

  always_ff @(posedge clk) begin
    x4   <= x3;
    h4   <= 5'(hx - 10'({4'b0, hp[19:14]} * 10'd30));
    ml4  <= ml3;
    dd4  <= dd3;
    dow4 <= mod7(13'(dcode3) + 13'(dd3));
    ydb4 <= ydb3;
  end

  // stage 5
  logic [6:0]         lx;
  logic [2:0]         d3;
  logic [5:0]         md;
  logic signed [4:0]  d4;
  logic signed [10:0] r4, roth_c, ylen;
  logic signed [10:0] dvx;

  year_info_t         x5;
  logic [4:0]         h5;
  logic [2:0]         l5;
  logic signed [10:0] roth5;

  always_comb begin
    lx  = 7'd32 + {4'b0, x4.e, 1'b0} + {1'b0, x4.i, 1'b0} - 7'(h4) - 7'(x4.k);
    dvx = {{3{x4.dv[7]}}, x4.dv};
    d3  = (x4.wk >= dow4) ? 3'(x4.wk - dow4) : 3'(x4.wk + 3'd7 - dow4);
    md  = 6'd1 + 6'(d3) + 6'(6'(x4.dv[2:0] - 3'd1) * 6'd7);
    if (x4.dv[2:0] == 3'd5 && md > 6'(ml4)) begin
      md = md - 6'd7;
    end
    d4   = $signed({2'b0, x4.wk}) - $signed({2'b0, dow4});
    ylen = x4.leap ? 11'sd366 : 11'sd365;
    r4   = $signed({2'b0, ydb4});
    if (dow4 != x4.wk) begin
      if ($signed({3'b0, dd4}) + 8'(d4) < x4.dv) begin
        d4 = d4 + 5'sd7;
      end
      r4 = r4 + 11'(d4);
      if (r4 >= ylen) begin
        r4 = r4 - ylen;
      end
    end
    unique case (x4.func)
      FN_ADVENT: roth_c = 11'sd357 + $signed({10'b0, x4.leap}) -
                          $signed({8'b0, dow4}) + dvx;
      FN_NTH:    roth_c = $signed({2'b0, days_before(x4.mon)}) + $signed({5'b0, md}) -
                          11'sd1 + $signed({10'b0, (x4.mon > MON_FEB) && x4.leap});
      FN_ONAFTER: roth_c = r4;
      default:   roth_c = $signed({2'b0, ydb4});
    endcase
  end

  always_ff @(posedge clk) begin
    x5    <= x4;
    h5    <= h4;
    l5    <= mod7(13'(lx));
    roth5 <= roth_c;
  end

  // stage 6
  logic [8:0]         mx;
  logic [7:0]         s;
  logic signed [10:0] easter, res;

  always_comb begin
    mx = 9'(x5.a) + 9'(9'(h5) * 9'd11) + 9'(9'(l5) * 9'd22);
    s  = 8'(h5) + 8'(l5) + 8'd114 - ((mx >= 9'd451) ? 8'd7 : 8'd0);
    easter = $signed({3'b0, s}) - 11'sd34 + $signed({10'b0, x5.leap}) +
             $signed({{3{x5.dv[7]}}, x5.dv});
    res = (x5.func == FN_EASTER) ? easter : roth5;
    if (!x5.ok) begin
      res = 11'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[1:0], in_vld};
      done <= vld[2];
    end
  end

  always_ff @(posedge clk) begin
    valid_res <= x5.ok;
    day_index <= res[9:0];
  end

endmodule

@@ hdl/holiday_rule_day_of_year.sv @@
// Holiday rule resolver top level: day of year of one rule in a given year.
// One item accepted every cycle.
// busy is always low; the pipeline has no stall path.
// Synchronous reset clears the valid bits; no result is pending after reset.
// Depends on hrd_pkg, hrd_year, hrd_resolve.
`timescale 1ns / 1ps
module holiday_rule_day_of_year import hrd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        func,
  input  logic [2:0]        weekday,
  input  logic [3:0]        month,
  input  logic signed [7:0] day_offset,
  input  logic [11:0]       rule_year,
  input  logic [11:0]       year,
  output logic              done,
  output logic              valid_res,
  output logic signed [9:0] day_index
);

  logic       yr_vld;
  year_info_t yr_info;

  assign busy = 1'b0;

  hrd_year u_year (
    .clk        (clk),
    .rst        (rst),
    .in_vld     (start),
    .func       (func),
    .weekday    (weekday),
    .month      (month),
    .day_offset (day_offset),
    .rule_year  (rule_year),
    .year       (year),
    .out_vld    (yr_vld),
    .info       (yr_info)
  );

  hrd_resolve u_resolve (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (yr_vld),
    .info      (yr_info),
    .done      (done),
    .valid_res (valid_res),
    .day_index (day_index)
  );

endmodule

@@ tb/holiday_rule_day_of_year_checker.sv @@
// Checker for the holiday rule resolver: predicts valid flag and day of year
// for every accepted item and compares each done strobe against the oldest.
// Depends on hrd_pkg for the rule kind codes.
`timescale 1ns / 1ps
module holiday_rule_day_of_year_checker import hrd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [2:0]        func,
  input  logic [2:0]        weekday,
  input  logic [3:0]        month,
  input  logic signed [7:0] day_offset,
  input  logic [11:0]       rule_year,
  input  logic [11:0]       year,
  input  logic              done,
  input  logic              valid_res,
  input  logic signed [9:0] day_index,
  output int                errors,
  output int                pending,
  output int                checked,
  output int                valid_seen
);

  typedef struct {
    logic       ok;
    logic [9:0] day;
  } day_result_t;

  day_result_t expected_days[$];

  function automatic bit leap_year(int y);
    return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
  endfunction

  function automatic int cum_days(int m);
    int t[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    return t[m - 1];
  endfunction

  function automatic int days_in_month(int y, int m);
    int t[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    return t[m - 1] + ((m == 2 && leap_year(y)) ? 1 : 0);
  endfunction

  function automatic int ordinal_day(int y, int m, int d);
    return cum_days(m) + d - 1 + ((m > 2 && leap_year(y)) ? 1 : 0);
  endfunction

  function automatic int week_day(int y, int m, int d);
    int off[12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
    int yy;
    yy = y + 400 - (m < 3 ? 1 : 0);
    return (yy + yy / 4 - yy / 100 + yy / 400 + off[m - 1] + d) % 7;
  endfunction

  function automatic int easter_day(int y);
    int a, b, c, d, e, f, g, h, i, k, l, m, s;
    a = y % 19; b = y / 100; c = y % 100;
    d = b / 4; e = b % 4;
    f = (b + 8) / 25;
    g = (b - f + 1) / 3;
    h = (19 * a + b - d - g + 15) % 30;
    i = c / 4; k = c % 4;
    l = (32 + 2 * e + 2 * i - h - k) % 7;
    m = (a + 11 * h + 22 * l) / 451;
    s = h + l - 7 * m + 114;
    return ordinal_day(y, s / 31, (s % 31) + 1);
  endfunction

  function automatic day_result_t resolve_rule(logic [2:0] fn, int wk, int mon, int dv,
                                               int ry, int y);
    day_result_t r;
    bit mok, ok;
    int res, delta, md, ml, nm, nd, wd, ylen;
    mok = mon >= 1 && mon <= 12;
    ok = 0;
    res = 0;
    case (fn)
      FN_FIXED: begin
        ok = mok && dv >= 1 && dv <= 31 && (ry == 0 || ry == y);
        if (ok) res = ordinal_day(y, mon, dv);
      end
      FN_EASTER: begin
        ok = mon == 0;
        if (ok) res = easter_day(y) + dv;
      end
      FN_ADVENT: begin
        ok = mon == 0;
        if (ok) res = ordinal_day(y, 12, 24) - week_day(y, 12, 24) + dv;
      end
      FN_NTH: begin
        ok = mok && dv >= 1 && dv <= 5 && wk <= 6;
        if (ok) begin
          delta = wk - week_day(y, mon, 1);
          if (delta < 0) delta += 7;
          md = 1 + delta + 7 * (dv - 1);
          if (dv == 5 && md > days_in_month(y, mon)) md -= 7;
          res = ordinal_day(y, mon, md);
        end
      end
      FN_ONAFTER: begin
        ok = mok && dv >= 1 && dv <= 31 && wk <= 6;
        if (ok) begin
          ml = days_in_month(y, mon);
          nm = mon;
          nd = dv;
          ylen = leap_year(y) ? 366 : 365;
          if (dv > ml) begin
            nd = dv - ml;
            nm = mon + 1;
          end
          res = ordinal_day(y, mon, dv);
          wd = week_day(y, nm, nd);
          if (wd != wk) begin
            delta = wk - wd;
            if (nd + delta < dv) delta += 7;
            res += delta;
            if (res >= ylen) res -= ylen;
          end
        end
      end
      default: ok = 0;
    endcase
    r.ok = ok;
    r.day = ok ? res[9:0] : 10'd0;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    day_result_t e;
    if (rst) begin
      expected_days.delete();
    end else begin
      if (done) begin
        if (expected_days.size() == 0) begin
          report_mismatch("unexpected result count", 1, 0);
        end else begin
          e = expected_days.pop_front();
          checked++;
          if (valid_res) valid_seen++;
          if (valid_res !== e.ok) report_mismatch("valid_res", valid_res, e.ok);
          if (day_index !== e.day)
            report_mismatch("day_index", int'(day_index), int'($signed(e.day)));
        end
      end
      if (start && !busy)
        expected_days.push_back(resolve_rule(func, weekday, month, int'(day_offset),
                                             rule_year, year));
    end
    pending = expected_days.size();
  end

endmodule

@@ tb/tb_holiday_rule_day_of_year.sv @@
// Testbench top for the holiday rule resolver: directed and random rules
// with random start gaps; the checker module predicts and compares.
// Depends on hrd_pkg, holiday_rule_day_of_year, holiday_rule_day_of_year_checker.
`timescale 1ns / 1ps
module tb_holiday_rule_day_of_year import hrd_pkg::*;;

  localparam int WATCHDOG_LIMIT = 2000;

  logic              clk, rst, start, busy, done, valid_res;
  logic [2:0]        func, weekday;
  logic [3:0]        month;
  logic signed [7:0] day_offset;
  logic [11:0]       rule_year, year;
  logic signed [9:0] day_index;
  int errors, pending, checked, valid_seen;
  int idle_cycles;
  bit stim_done;

  holiday_rule_day_of_year DUT (.*);

  holiday_rule_day_of_year_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  task automatic send_rule(logic [2:0] fn, logic [2:0] wk, logic [3:0] mon,
                           logic [7:0] dv, logic [11:0] ry, logic [11:0] y);
    int gap;
    if ($urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    func <= fn;
    weekday <= wk;
    month <= mon;
    day_offset <= dv;
    rule_year <= ry;
    year <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [11:0] pick_year();
    case ($urandom_range(0, 9))
      0: return 12'($urandom_range(0, 4095));
      1: return 12'(400 * $urandom_range(4, 10));
      2: return 12'(100 * $urandom_range(16, 40));
      default: return 12'($urandom_range(1583, 4095));
    endcase
  endfunction

  initial begin
    logic [2:0] fn;
    logic [3:0] mon;
    logic [7:0] dv;
    logic [11:0] y, ry;
    rst = 1;
    start = 0;
    func = 0;
    weekday = 0;
    month = 0;
    day_offset = 0;
    rule_year = 0;
    year = 1583;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_rule(FN_FIXED, 0, 1, 1, 0, 1583);
    send_rule(FN_FIXED, 0, 12, 31, 4095, 4095);
    send_rule(FN_FIXED, 0, 2, 31, 0, 2000);
    send_rule(FN_FIXED, 0, 2, 30, 1999, 2000);
    send_rule(FN_FIXED, 0, 0, 10, 0, 2000);
    send_rule(FN_FIXED, 0, 13, 32, 0, 2000);
    send_rule(FN_EASTER, 7, 0, 8'h80, 0, 2024);
    send_rule(FN_EASTER, 0, 0, 8'h7f, 0, 4095);
    send_rule(FN_EASTER, 0, 3, 0, 0, 2024);
    send_rule(FN_ADVENT, 0, 0, 8'hf3, 0, 1583);
    send_rule(FN_ADVENT, 0, 15, 0, 0, 2100);
    send_rule(FN_NTH, 1, 1, 5, 0, 2023);
    send_rule(FN_NTH, 6, 2, 5, 0, 2000);
    send_rule(FN_NTH, 7, 5, 1, 0, 2023);
    send_rule(FN_NTH, 3, 11, 6, 0, 2023);
    send_rule(FN_ONAFTER, 0, 12, 31, 0, 2023);
    send_rule(FN_ONAFTER, 3, 2, 31, 0, 2001);
    send_rule(FN_ONAFTER, 6, 4, 31, 0, 2400);
    send_rule(FN_ONAFTER, 7, 6, 1, 0, 2024);
    send_rule(FN_ONAFTER, 2, 6, 0, 0, 2024);
    send_rule(3'd5, 0, 1, 1, 0, 2024);
    send_rule(3'd7, 7, 15, 8'hff, 12'hfff, 12'h000);

    repeat (1400) begin
      y = pick_year();
      fn = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      mon = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
          : (fn == FN_EASTER || fn == FN_ADVENT) ? 4'd0 : 4'($urandom_range(1, 12));
      case ($urandom_range(0, 9))
        0: dv = 8'($urandom_range(0, 255));
        1: dv = 8'($urandom_range(27, 31));
        default: dv = (fn == FN_NTH) ? 8'($urandom_range(1, 5))
                    : (fn == FN_EASTER || fn == FN_ADVENT) ? 8'($urandom_range(0, 255))
                    : 8'($urandom_range(1, 31));
      endcase
      ry = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
         : ($urandom_range(0, 1) ? y : 12'd0);
      send_rule(fn, ($urandom_range(0, 15) == 0) ? 3'd7 : 3'($urandom_range(0, 6)),
                mon, dv, ry, y);
    end
    start <= 0;
    stim_done = 1;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    $display("Resolved %0d rules across all five kinds and unknown codes, %0d valid",
             checked, valid_seen);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ holiday_rule_day_of_year.f @@
hdl/hrd_pkg.sv
hdl/hrd_year.sv
hdl/hrd_resolve.sv
hdl/holiday_rule_day_of_year.sv
tb/holiday_rule_day_of_year_checker.sv
tb/tb_holiday_rule_day_of_year.sv
